// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers for the checker file olw_checker.sv
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every rising edge, reset included
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/olw_pkg.sv =====
// ----------------------------------------------------------------------------
// olw_pkg
// shared types and constants of the orthogonal step line walker
// ----------------------------------------------------------------------------
package olw_pkg;

   localparam int COORD_W     = 5;
   localparam int WIDTH_W     = 6;
   localparam int INDEX_W     = 10;
   localparam int ERR_W       = 11;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;
   localparam int GRID_SIDE   = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [WIDTH_W-1:0] GRID_WIDTH_RESET = WIDTH_W'(GRID_SIDE);

   typedef logic [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x0;
      coord_type y0;
      coord_type nx;
      coord_type ny;
      logic      right;
      logic      down;
   } line_type;

   typedef enum logic {
      WALK_IDLE,
      WALK_RUN
   } walk_state_type;

endpackage

// ===== design/olw_front.sv =====
// ----------------------------------------------------------------------------
// olw_front
// accepts a line request and derives step counts and directions
// ----------------------------------------------------------------------------
module olw_front (
   input  logic [olw_pkg::REQ_TDATA_W-1:0] req_tdata,
   output olw_pkg::line_type               line_desc
);
   import olw_pkg::*;

   coord_type x0;
   coord_type y0;
   coord_type x1;
   coord_type y1;

   assign x0 = req_tdata[COORD_W-1:0];
   assign y0 = req_tdata[2*COORD_W-1:COORD_W];
   assign x1 = req_tdata[3*COORD_W-1:2*COORD_W];
   assign y1 = req_tdata[4*COORD_W-1:3*COORD_W];

   always_comb begin
      line_desc.x0    = x0;
      line_desc.y0    = y0;
      line_desc.right = x1 > x0;
      line_desc.down  = y1 > y0;
      line_desc.nx    = (x1 > x0) ? (x1 - x0) : (x0 - x1);
      line_desc.ny    = (y1 > y0) ? (y1 - y0) : (y0 - y1);
   end

endmodule

// ===== design/olw_queue.sv =====
// ----------------------------------------------------------------------------
// olw_queue
// small fifo of line descriptors between front and walker
// ----------------------------------------------------------------------------
module olw_queue #(
   parameter int DEPTH = olw_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  olw_pkg::line_type push_data,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output olw_pkg::line_type head_data
);
   import olw_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   line_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/olw_back.sv =====
// ----------------------------------------------------------------------------
// olw_back
// walks one line a cell per cycle, unless stalled, into a result register
// ----------------------------------------------------------------------------
module olw_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [olw_pkg::WIDTH_W-1:0]       csr_wr_data,
   input  logic                              q_valid,
   input  olw_pkg::line_type                 q_data,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [olw_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);
   import olw_pkg::*;

   walk_state_type       state_ff, state_in;
   logic [WIDTH_W-1:0]   grid_width_ff, grid_width_in;
   line_type             line_ff, line_in;
   coord_type            x_ff, x_in;
   coord_type            y_ff, y_in;
   coord_type            i_ff, i_in;
   coord_type            j_ff, j_in;
   logic [ERR_W-1:0]     a_ff, a_in;
   logic [ERR_W-1:0]     b_ff, b_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   coord_type            rsp_x_ff, rsp_x_in;
   coord_type            rsp_y_ff, rsp_y_in;
   logic [INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 can_load;
   logic                 cur_last;
   logic [ERR_W-1:0]     row_offset;

   assign can_load   = !rsp_valid_ff || rsp_tready;
   assign cur_last   = (i_ff == line_ff.nx) && (j_ff == line_ff.ny);
   assign row_offset = ERR_W'(y_ff) * ERR_W'(grid_width_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - INDEX_W - 2*COORD_W){1'b0}},
                        rsp_index_ff, rsp_y_ff, rsp_x_ff};

   always_comb begin
      state_in      = state_ff;
      grid_width_in = csr_wr_en ? csr_wr_data : grid_width_ff;
      line_in       = line_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      q_pop         = 1'b0;

      if (can_load) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         WALK_IDLE: begin
            q_pop = q_valid;
         end
         WALK_RUN: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = x_ff;
               rsp_y_in     = y_ff;
               rsp_index_in = INDEX_W'(x_ff) + row_offset[INDEX_W-1:0];
               rsp_last_in  = cur_last;
               if (cur_last) begin
                  q_pop    = q_valid;
                  state_in = WALK_IDLE;
               end else if (a_ff < b_ff) begin
                  x_in = line_ff.right ? x_ff + 1'b1 : x_ff - 1'b1;
                  i_in = i_ff + 1'b1;
                  a_in = a_ff + ERR_W'({line_ff.ny, 1'b0});
               end else begin
                  y_in = line_ff.down ? y_ff + 1'b1 : y_ff - 1'b1;
                  j_in = j_ff + 1'b1;
                  b_in = b_ff + ERR_W'({line_ff.nx, 1'b0});
               end
            end
         end
         default: begin
            state_in = WALK_IDLE;
         end
      endcase

      if (q_pop) begin
         state_in = WALK_RUN;
         line_in  = q_data;
         x_in     = q_data.x0;
         y_in     = q_data.y0;
         i_in     = '0;
         j_in     = '0;
         a_in     = ERR_W'(q_data.ny);
         b_in     = ERR_W'(q_data.nx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= WALK_IDLE;
         grid_width_ff <= GRID_WIDTH_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         grid_width_ff <= grid_width_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff      <= line_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

// ===== design/orthogonal_step_line_walker_top.sv =====
// a request passes the queue, the walker registers and the result register
// throughput: a cell per cycle unless stalled; nx+ny+1 cells a line (1 to 63)
// the walker steps a cell per cycle unless stalled and pops the next line
// with the prior line's last cell; up to QUEUE_DEPTH lines wait in the queue
// reset: synchronous, empties queue and walker, grid width returns to 32
// ----------------------------------------------------------------------------
// orthogonal_step_line_walker_top
// four-connected line walker: request front, descriptor queue, cell walker
// ----------------------------------------------------------------------------
module orthogonal_step_line_walker_top #(
   parameter int QUEUE_DEPTH = olw_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [olw_pkg::WIDTH_W-1:0]     csr_wr_data,   // grid_width
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // start_x[4:0], start_y[9:5], end_x[14:10], end_y[19:15], zero pad
   input  logic [olw_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cell_x[4:0], cell_y[9:5], cell_index[19:10], zero pad
   output logic [olw_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast       // last_cell
);
   import olw_pkg::*;

   line_type front_line;
   line_type head_line;
   logic     q_full;
   logic     q_valid;
   logic     q_pop;

   assign req_tready = !q_full;

   olw_front u_front (
      .req_tdata (req_tdata),
      .line_desc (front_line)
   );

   olw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid),
      .push_data  (front_line),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_data  (head_line)
   );

   olw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_data      (head_line),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ===== design/olw_checker.sv =====
// ----------------------------------------------------------------------------
// olw_checker
// port-level checks of the line walker, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module olw_checker (
   input logic clock,
   input logic reset,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic rsp_tlast
);

   // output stage is empty right after reset
   `ASSERT_CLK_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_tvalid, "rsp valid after reset")

   // cells of one line leave back to back
   `ASSERT_CLK(a_line_no_gap, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid, "gap inside a line")

   // stalled result stays offered
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp valid dropped while stalled")

endmodule

bind orthogonal_step_line_walker_top olw_checker u_olw_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/sv/tb_orthogonal_step_line_walker_top.sv =====
// ----------------------------------------------------------------------------
// tb_orthogonal_step_line_walker_top
// Self-checking bench for the four-connected line walker. Each request
// transaction carries a start and an end point. A behavioral tracer
// expands it into the expected chain of cells and compares every
// response transaction with the oldest expected cell. A directed table of
// endpoints runs first, followed by random lines under several grid widths.
// Both stream sides see random idle bursts, except in the final phase.
// ----------------------------------------------------------------------------
module tb_orthogonal_step_line_walker_top;
   timeunit 1ns;
   timeprecision 1ps;

   import olw_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int LINES_PER_PHASE = 35;

   typedef struct {
      coord_type          x;
      coord_type          y;
      logic [INDEX_W-1:0] index;
      logic               last;
   } cell_type;

   typedef struct {
      int sx;
      int sy;
      int ex;
      int ey;
      bit typed;
      int index;
   } line_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [WIDTH_W-1:0]     csr_wr_data;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;

   cell_type pending_cells[$];
   int       grid_width = GRID_SIDE;
   int       error_count = 0;
   int       idle_cycles = 0;
   bit       quiet = 1'b0;

   // single-point rows carry their one cell typed in
   line_row_type directed_lines [23] = '{
      '{0, 0, 0, 0, 1, 0},
      '{31, 31, 31, 31, 1, 1023},
      '{31, 0, 31, 0, 1, 31},
      '{0, 31, 0, 31, 1, 992},
      '{21, 10, 21, 10, 1, 341},
      '{10, 21, 10, 21, 1, 682},
      '{0, 0, 31, 31, 0, 0},
      '{31, 31, 0, 0, 0, 0},
      '{0, 31, 31, 0, 0, 0},
      '{31, 0, 0, 31, 0, 0},
      '{0, 5, 31, 5, 0, 0},
      '{31, 5, 0, 5, 0, 0},
      '{7, 0, 7, 31, 0, 0},
      '{7, 31, 7, 0, 0, 0},
      '{4, 4, 5, 5, 0, 0},
      '{4, 4, 3, 3, 0, 0},
      '{0, 0, 3, 3, 0, 0},
      '{10, 10, 11, 10, 0, 0},
      '{10, 10, 10, 9, 0, 0},
      '{2, 3, 9, 5, 0, 0},
      '{20, 1, 3, 30, 0, 0},
      '{21, 10, 10, 21, 0, 0},
      '{10, 21, 21, 10, 0, 0}
   };

   orthogonal_step_line_walker_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic cell_type make_cell(int x, int y, bit last);
      cell_type c;
      c.x     = coord_type'(x);
      c.y     = coord_type'(y);
      c.index = INDEX_W'(x + y * grid_width);
      c.last  = last;
      return c;
   endfunction

   // expands one line into its visited cells, start cell first
   function automatic void trace_line(int sx, int sy, int ex, int ey);
      int nx;
      int ny;
      int x;
      int y;
      int h;
      int v;
      nx = (ex > sx) ? ex - sx : sx - ex;
      ny = (ey > sy) ? ey - sy : sy - ey;
      x = sx;
      y = sy;
      h = 0;
      v = 0;
      pending_cells.push_back(make_cell(x, y, nx == 0 && ny == 0));
      while (h < nx || v < ny) begin
         if ((1 + 2 * h) * ny < (1 + 2 * v) * nx) begin
            x = (ex > sx) ? x + 1 : x - 1;
            h++;
         end else begin
            y = (ey > sy) ? y + 1 : y - 1;
            v++;
         end
         pending_cells.push_back(make_cell(x, y, h == nx && v == ny));
      end
   endfunction

   task automatic send_line(int sx, int sy, int ex, int ey);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tdata  <= REQ_TDATA_W'({coord_type'(ey), coord_type'(ex),
                                  coord_type'(sy), coord_type'(sx)});
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_cells();
      req_tvalid <= 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_grid_width(int w);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= WIDTH_W'(w);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      grid_width  = w & ((1 << WIDTH_W) - 1);
   endtask

   task automatic random_line(output int sx, output int sy, output int ex, output int ey);
      int n;
      sx = $urandom_range(0, 31);
      sy = $urandom_range(0, 31);
      ex = $urandom_range(0, 31);
      ey = $urandom_range(0, 31);
      case ($urandom_range(0, 9))
         0: begin
            ex = sx;
            ey = sy;
         end
         1: ey = sy;
         2: ex = sx;
         3, 4: begin
            ex = sx + int'($urandom_range(0, 6)) - 3;
            ey = sy + int'($urandom_range(0, 6)) - 3;
            ex = (ex < 0) ? 0 : (ex > 31) ? 31 : ex;
            ey = (ey < 0) ? 0 : (ey > 31) ? 31 : ey;
         end
         5: begin
            n = $urandom_range(0, 15);
            ex = (sx < 16) ? sx + n : sx - n;
            ey = (sy < 16) ? sy + n : sy - n;
         end
         6: begin
            n = $urandom_range(0, 7);
            ex = (sx < 16) ? sx + 2 * n : sx - 2 * n;
            ey = (sy < 16) ? sy + n : sy - n;
         end
         default: ;
      endcase
   endtask

   // response side ready with random stall bursts
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cell_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cells.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected cell transaction: tdata=%h last=%b", rsp_tdata, rsp_tlast);
         end else begin
            want = pending_cells.pop_front();
            if (rsp_tdata !== RSP_TDATA_W'({want.index, want.y, want.x})
                || rsp_tlast !== want.last) begin
               error_count++;
               if (error_count <= 10)
                  $display("cell mismatch: expected x=%0d y=%0d index=%0d last=%0d, got x=%0d y=%0d index=%0d last=%0d tdata=%h",
                           want.x, want.y, want.index, want.last,
                           rsp_tdata[4:0], rsp_tdata[9:5], rsp_tdata[19:10], rsp_tlast,
                           rsp_tdata);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("timeout with %0d cells outstanding", pending_cells.size());
      $display("[orthogonal_step_line_walker_top] ERROR");
      $finish;
   end

   initial begin
      line_row_type r;
      int sx;
      int sy;
      int ex;
      int ey;
      int widths [6];
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_lines[k]) begin
         r = directed_lines[k];
         send_line(r.sx, r.sy, r.ex, r.ey);
         if (r.typed)
            pending_cells.push_back('{coord_type'(r.sx), coord_type'(r.sy),
                                      INDEX_W'(r.index), 1'b1});
         else
            trace_line(r.sx, r.sy, r.ex, r.ey);
      end

      widths = '{1, 0, 63, 33, 2, 32};
      widths[4] = $urandom_range(2, 31);
      for (int p = 0; p < 6; p++) begin
         drain_cells();
         if (p == 5)
            quiet = 1'b1;
         set_grid_width(widths[p]);
         for (int n = 0; n < LINES_PER_PHASE; n++) begin
            // hold off mid-phase until the walker has emptied
            if (p == 2 && n == LINES_PER_PHASE / 2)
               drain_cells();
            random_line(sx, sy, ex, ey);
            send_line(sx, sy, ex, ey);
            trace_line(sx, sy, ex, ey);
         end
      end

      drain_cells();
      repeat (8) @(posedge clock);
      if (pending_cells.size() != 0) begin
         $display("missing %0d cell transactions", pending_cells.size());
         error_count += pending_cells.size();
      end
      if (error_count == 0) begin
         $display("[orthogonal_step_line_walker_top] OK");
      end else begin
         $display("[orthogonal_step_line_walker_top] ERROR");
      end
      $finish;
   end

endmodule
